@@ rtl/ibt_pkg.sv @@
// shared types and constants for the interval booking table
package ibt_pkg;

    localparam int TIME_W   = 30;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 7;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_BOOKED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // one half-open interval [start, end)
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } interval_t;

    // per-cycle controls broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

@@ rtl/ibt_cell.sv @@
// one table cell: holds a stored interval, checks it against a request, shifts on insert
module ibt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                 clk,
    input  ibt_pkg::cell_ctrl_t  ctrl,
    input  logic [CNT_W-1:0]     count,
    input  ibt_pkg::interval_t   req,
    input  ibt_pkg::interval_t   prev,
    output ibt_pkg::interval_t   entry,
    output logic                 hit
);

    ibt_pkg::interval_t entry_reg;
    logic               hit_reg;
    logic               active;
    logic               overlap;

    // cell holds a live entry when its position is below the fill level
    assign active  = CNT_W'(INDEX) < count;
    assign overlap = (entry_reg.end_time > req.start_time)
                  && (req.end_time > entry_reg.start_time);

    // capture the compare result for the decision cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            hit_reg <= active && overlap;
        end
    end

    // take the neighbor's interval when a new one is pushed in at the head
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            entry_reg <= prev;
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

@@ rtl/interval_booking_table.sv @@
// top level of the interval booking table: control and the row of cells
//
//  channel   signals                               direction
//  request   in_valid, in_ready, start_time,       in
//            end_time
//  result    out_valid, out_ready, status,         out
//            entries_used
//
// An item passes an accept step and a decision step: in the accept cycle every
// cell compares its stored interval with the request and registers a hit; in the
// S_DECIDE state the hits are or-ed, the status is decided and, when booked, the
// row shifts by one cell with the new interval entering cell 0. The result sits in
// an output register; the decision cycle waits only while that register still
// holds an untaken result. Reset empties the table (fill count to zero).
module interval_booking_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ibt_pkg::TIME_W-1:0]    start_time,
    input  logic [ibt_pkg::TIME_W-1:0]    end_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ibt_pkg::STATUS_W-1:0]  status,
    output logic [ibt_pkg::USED_W-1:0]    entries_used
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_DECIDE = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          out_valid_reg, out_valid_next;
    logic [ibt_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [ibt_pkg::USED_W-1:0]    used_reg, used_next;
    ibt_pkg::interval_t            req_reg;
    ibt_pkg::interval_t            req_in;
    ibt_pkg::cell_ctrl_t           ctrl;
    ibt_pkg::interval_t            chain [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0]        hit_vec;
    logic                          accept_in;
    logic                          commit;
    logic                          any_hit;
    logic                          full;

    assign req_in.start_time = start_time;
    assign req_in.end_time   = end_time;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept_in = in_valid && in_ready;
    assign commit    = (state_reg == S_DECIDE) && (!out_valid_reg || out_ready);
    assign any_hit   = |hit_vec;
    assign full      = count_reg >= CNT_W'(MAX_ENTRIES);

    // cells compare against the live request in the accept cycle
    assign ctrl.cmp_en   = accept_in;
    assign ctrl.shift_en = commit && !any_hit && !full;

    // request held for the insert in the decision cycle
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            req_reg <= req_in;
        end
    end

    // row of cells, new interval enters at the head
    assign chain[0] = req_reg;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        ibt_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .count (count_reg),
            .req   (req_in),
            .prev  (chain[i]),
            .entry (chain[i+1]),
            .hit   (hit_vec[i])
        );
    end

    // sequencing, decision and output register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        used_next      = used_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (commit)
                begin
                    if (any_hit)
                    begin
                        status_next = ibt_pkg::ST_OVERLAP;
                    end
                    else if (full)
                    begin
                        status_next = ibt_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = ibt_pkg::ST_BOOKED;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    used_next      = ibt_pkg::USED_W'(count_next);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        used_reg   <= used_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entries_used = used_reg;

endmodule
